@@ rtl/calendar_to_epoch_converter_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the calendar to epoch converter
// Clocked, reset-qualified property wrappers shared by the core.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_TO_EPOCH_CONVERTER_CORE_ASSERT_SVH
`define CALENDAR_TO_EPOCH_CONVERTER_CORE_ASSERT_SVH

// Property that must hold on every edge out of reset
`define C2E_ASSERT_ALWAYS(name, ck, rs, prop, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);

// Same-cycle implication out of reset
`define C2E_ASSERT_IMPLIES(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/c2e_pkg.sv @@
// ----------------------------------------------------------------------------
// c2e_pkg
// Status codes, calendar tables and fixed constants of the date converter.
// ----------------------------------------------------------------------------
package c2e_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_FIELD = 3'd1,
    ST_EARLY_YEAR = 3'd2,
    ST_BAD_HOUR   = 3'd3,
    ST_BAD_MINUTE = 3'd4,
    ST_BAD_SECOND = 3'd5,
    ST_BAD_MONTH  = 3'd6,
    ST_BAD_DAY    = 3'd7
  } status_t;

  // Fields the validity checks look at, after the first stage
  typedef struct packed {
    logic [13:0] year;
    logic [7:0]  year_q100;   // year / 100
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [16:0] sec_ms;      // second * 1000 + millisecond
  } chk_fields_t;

  localparam int unsigned MIN_YEAR          = 1950;
  localparam int unsigned MAX_SEC_MS        = 59999;
  localparam int unsigned MS_PER_SEC        = 1000;
  localparam int unsigned MS_PER_MIN        = 60000;
  localparam int unsigned MS_PER_HOUR       = 3600000;
  localparam int unsigned DAYS_PER_YEAR     = 365;
  localparam int unsigned EPOCH_DAY_OFFSET  = 719468;
  // floor(x * RECIP_100 / 2^19) == x / 100 for every 14-bit x
  localparam int unsigned RECIP_100         = 5243;
  localparam int unsigned RECIP_SHIFT       = 19;

  localparam logic signed [27:0] MS_PER_DAY = 28'sd86400000;
  localparam logic signed [51:0] EPOCH_MAX  = 52'sd281474976710655;
  localparam logic signed [48:0] EPOCH_MIN  = -49'sd631152000000;

  // Day of year at the first of the month, years starting in March
  function automatic logic [8:0] month_offset(input logic [6:0] m);
    logic [8:0] r;
    case (m)
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month in a common year
  function automatic logic [4:0] month_len(input logic [6:0] m);
    logic [4:0] r;
    case (m)
      7'd2:                  r = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
      default:               r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/c2e_check.sv @@
// ----------------------------------------------------------------------------
// c2e_check
// Field validation in priority order, Gregorian leap rule for February.
// ----------------------------------------------------------------------------
module c2e_check (
  input  c2e_pkg::chk_fields_t f,
  output c2e_pkg::status_t     status
);
  import c2e_pkg::*;

  logic       century;
  logic       leap;
  logic [4:0] lim;

  // Leap year: divisible by 4, and not a century unless divisible by 400
  assign century = ({1'b0, f.year} == 15'(f.year_q100) * 15'd100);
  assign leap    = (f.year[1:0] == 2'b00) && (!century || (f.year_q100[1:0] == 2'b00));
  assign lim     = (f.month == 7'd2 && leap) ? 5'd29 : month_len(f.month);

  // First failing check sets the code
  always_comb begin
    if (f.year == '0 || f.month == '0 || f.day == '0) begin
      status = ST_ZERO_FIELD;
    end else if (f.year < 14'(MIN_YEAR)) begin
      status = ST_EARLY_YEAR;
    end else if (f.hour > 7'd23) begin
      status = ST_BAD_HOUR;
    end else if (f.minute > 7'd59) begin
      status = ST_BAD_MINUTE;
    end else if (f.sec_ms > 17'(MAX_SEC_MS)) begin
      status = ST_BAD_SECOND;
    end else if (f.month > 7'd12) begin
      status = ST_BAD_MONTH;
    end else if (f.day > {2'b00, lim}) begin
      status = ST_BAD_DAY;
    end else begin
      status = ST_OK;
    end
  end

endmodule

@@ rtl/calendar_to_epoch_converter_core.sv @@
// ----------------------------------------------------------------------------
// calendar_to_epoch_converter_core: UTC calendar date/time to Unix milliseconds
// An accepted input beat passes through register stages 1 to 4; its result is driven from stage 4.
// Throughput: one beat per cycle while out_stall is low; four register stages, bubbles are squeezed.
// Reset clears the stage valid bits only; the datapath registers are not reset.
// ----------------------------------------------------------------------------
`include "calendar_to_epoch_converter_core_assert.svh"

module calendar_to_epoch_converter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [13:0]        year,
  input  logic [6:0]         month,
  input  logic [6:0]         day,
  input  logic [6:0]         hour,
  input  logic [6:0]         minute,
  input  logic [6:0]         second,
  input  logic [9:0]         millisecond,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [48:0] epoch_ms,
  output logic [2:0]         status
);
  import c2e_pkg::*;

  // Stage valid bits and per-stage advance
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = !v4 || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: shifted year, /100 by reciprocal, day of year, seconds in ms
  // --------------------------------------------------------------------------
  logic [13:0] yy_c;
  logic [26:0] yy_prod_c;
  logic [26:0] y_prod_c;
  logic [16:0] sec_ms_c;
  logic [8:0]  doy_c;

  assign yy_c      = (month <= 7'd2) ? year - 14'd1 : year;
  assign yy_prod_c = 27'(yy_c) * 27'(RECIP_100);
  assign y_prod_c  = 27'(year) * 27'(RECIP_100);
  assign sec_ms_c  = 17'(second) * 17'(MS_PER_SEC) + 17'(millisecond);
  assign doy_c     = month_offset(month) + 9'(day) - 9'd1;

  chk_fields_t s1_chk;
  logic [13:0] s1_yy;
  logic [7:0]  s1_yy_q100;
  logic [8:0]  s1_doy;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_chk.year      <= year;
      s1_chk.year_q100 <= y_prod_c[RECIP_SHIFT +: 8];
      s1_chk.month     <= month;
      s1_chk.day       <= day;
      s1_chk.hour      <= hour;
      s1_chk.minute    <= minute;
      s1_chk.sec_ms    <= sec_ms_c;
      s1_yy            <= yy_c;
      s1_yy_q100       <= yy_prod_c[RECIP_SHIFT +: 8];
      s1_doy           <= doy_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: validate, day number relative to the epoch, time of day in ms
  // --------------------------------------------------------------------------
  status_t            status_c;
  logic [22:0]        base_c;
  logic signed [24:0] days_c;
  logic [29:0]        tod_c;

  c2e_check u_check (
    .f      (s1_chk),
    .status (status_c)
  );

  assign base_c = 23'(s1_yy) * 23'(DAYS_PER_YEAR) + 23'(s1_yy[13:2])
                - 23'(s1_yy_q100) + 23'(s1_yy_q100[7:2]);
  assign days_c = $signed(25'(base_c) + 25'(s1_doy) - 25'(EPOCH_DAY_OFFSET));
  assign tod_c  = 30'(s1_chk.hour) * 30'(MS_PER_HOUR)
                + 30'(s1_chk.minute) * 30'(MS_PER_MIN) + 30'(s1_chk.sec_ms);

  status_t            s2_status;
  logic signed [24:0] s2_days;
  logic [29:0]        s2_tod;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_status <= status_c;
      s2_days   <= days_c;
      s2_tod    <= tod_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: days to milliseconds
  // --------------------------------------------------------------------------
  logic signed [51:0] prod_c;

  assign prod_c = s2_days * MS_PER_DAY;

  status_t            s3_status;
  logic signed [51:0] s3_prod;
  logic [29:0]        s3_tod;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_status <= s2_status;
      s3_prod   <= prod_c;
      s3_tod    <= s2_tod;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: add time of day, saturate, drop the value on error
  // --------------------------------------------------------------------------
  logic signed [51:0] t_c;
  logic signed [48:0] t_out_c;

  assign t_c = s3_prod + $signed({22'b0, s3_tod});

  always_comb begin
    if (s3_status != ST_OK) begin
      t_out_c = '0;
    end else if (t_c > EPOCH_MAX) begin
      t_out_c = EPOCH_MAX[48:0];
    end else begin
      t_out_c = t_c[48:0];
    end
  end

  status_t s4_status;

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      epoch_ms  <= t_out_c;
      s4_status <= s3_status;
    end
  end

  assign out_valid = v4;
  assign status    = s4_status;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `C2E_ASSERT_IMPLIES(a_err_zero, clk, rst, out_valid && (s4_status != ST_OK), epoch_ms == '0, "error beat carries nonzero time")
  `C2E_ASSERT_IMPLIES(a_ok_floor, clk, rst, out_valid && (s4_status == ST_OK), epoch_ms >= EPOCH_MIN, "valid time below 1950")
  `C2E_ASSERT_IMPLIES(a_stall_full, clk, rst, in_stall, v1 && v2 && v3 && v4, "input held while pipeline has a bubble")

endmodule

@@ sim/calendar_to_epoch_checker.sv @@
// ----------------------------------------------------------------------------
// calendar_to_epoch_checker
// Watches both channels of the date converter, computes the Unix time and
// status that each accepted input beat should give, and compares every
// output beat field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module calendar_to_epoch_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [13:0]        year,
  input  logic [6:0]         month,
  input  logic [6:0]         day,
  input  logic [6:0]         hour,
  input  logic [6:0]         minute,
  input  logic [6:0]         second,
  input  logic [9:0]         millisecond,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [48:0] epoch_ms,
  input  logic [2:0]         status,
  output int unsigned        mismatch_count,
  output int unsigned        in_flight
);
  import c2e_pkg::*;

  typedef struct {
    logic signed [48:0] epoch;
    status_t            st;
  } stamp_t;

  localparam longint SAT_MS = (longint'(1) << 48) - 1;

  stamp_t pending_stamps[$];

  initial begin
    mismatch_count = 0;
    in_flight      = 0;
  end

  // Work out the time stamp and status of one calendar beat
  function automatic stamp_t convert_stamp(input logic [13:0] yr, input logic [6:0] mo,
                                           input logic [6:0] dy, input logic [6:0] hr,
                                           input logic [6:0] mn, input logic [6:0] sc,
                                           input logic [9:0] ms);
    stamp_t res;
    longint frac_ms, yr_adj, mar_idx, day_num, tot;
    int unsigned dim;
    bit leap;
    res.epoch = '0;
    res.st    = ST_OK;
    frac_ms   = longint'(sc) * 1000 + longint'(ms);
    leap      = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (mo)
      7'd2:                    dim = leap ? 29 : 28;
      7'd4, 7'd6, 7'd9, 7'd11: dim = 30;
      default:                 dim = 31;
    endcase

    // First failing check sets the status
    if (yr == 0 || mo == 0 || dy == 0)
      res.st = ST_ZERO_FIELD;
    else if (yr < MIN_YEAR)
      res.st = ST_EARLY_YEAR;
    else if (hr > 23)
      res.st = ST_BAD_HOUR;
    else if (mn > 59)
      res.st = ST_BAD_MINUTE;
    else if (frac_ms > MAX_SEC_MS)
      res.st = ST_BAD_SECOND;
    else if (mo > 12)
      res.st = ST_BAD_MONTH;
    else if (dy > dim)
      res.st = ST_BAD_DAY;

    if (res.st == ST_OK) begin
      // Count days with the year starting in March, so leap days fall last
      yr_adj  = (mo <= 2) ? longint'(yr) - 1 : longint'(yr);
      mar_idx = (longint'(mo) + 9) % 12;
      day_num = 365 * yr_adj + yr_adj / 4 - yr_adj / 100 + yr_adj / 400
              + (153 * mar_idx + 2) / 5 + longint'(dy) - 1 - 719468;
      tot = day_num * 86400000 + longint'(hr) * 3600000 + longint'(mn) * 60000 + frac_ms;
      if (tot > SAT_MS)
        tot = SAT_MS;
      res.epoch = tot[48:0];
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endtask

  // Queue a prediction per input beat, compare per output beat
  always @(posedge clk) begin
    stamp_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        pending_stamps.push_back(convert_stamp(year, month, day, hour, minute, second,
                                               millisecond));
      if (out_valid && !out_stall) begin
        if (pending_stamps.size() == 0) begin
          note_mismatch("unexpected beat, epoch_ms", 0, epoch_ms);
        end else begin
          want = pending_stamps.pop_front();
          if (epoch_ms !== want.epoch)
            note_mismatch("epoch_ms", want.epoch, epoch_ms);
          if (status !== want.st)
            note_mismatch("status", want.st, status);
        end
      end
    end
    in_flight <= pending_stamps.size();
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives calendar dates into the epoch converter: a directed set of edge
// dates and every error class, then random dates, mostly well formed, with
// random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [13:0]        year        = '0;
  logic [6:0]         month       = '0;
  logic [6:0]         day         = '0;
  logic [6:0]         hour        = '0;
  logic [6:0]         minute      = '0;
  logic [6:0]         second      = '0;
  logic [9:0]         millisecond = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [48:0] epoch_ms;
  logic [2:0]         status;
  logic               steady      = 1'b0;
  int unsigned        mismatch_count;
  int unsigned        in_flight;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  calendar_to_epoch_converter_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .millisecond (millisecond),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .epoch_ms    (epoch_ms),
    .status      (status)
  );

  calendar_to_epoch_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .year           (year),
    .month          (month),
    .day            (day),
    .hour           (hour),
    .minute         (minute),
    .second         (second),
    .millisecond    (millisecond),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .epoch_ms       (epoch_ms),
    .status         (status),
    .mismatch_count (mismatch_count),
    .in_flight      (in_flight)
  );

  // Stall the output at random, except during the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 24);
  end

  // Present one beat, with an occasional gap first, and hold it until taken
  task automatic send_beat(input int unsigned y, input int unsigned mo, input int unsigned dy,
                           input int unsigned hr, input int unsigned mn, input int unsigned sc,
                           input int unsigned ms);
    if (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    year        <= 14'(y);
    month       <= 7'(mo);
    day         <= 7'(dy);
    hour        <= 7'(hr);
    minute      <= 7'(mn);
    second      <= 7'(sc);
    millisecond <= 10'(ms);
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the input idle until every expected beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic send_random();
    int unsigned pick, y, mo, dy, hr, mn, sc, ms;
    pick = $urandom_range(99);
    y    = $urandom_range(2100, 1950);
    mo   = $urandom_range(12, 1);
    dy   = $urandom_range(31, 1);
    hr   = $urandom_range(23);
    mn   = $urandom_range(59);
    sc   = $urandom_range(59);
    ms   = $urandom_range(999);
    if (pick >= 90) begin
      // Century years, late February and the end of the minute
      y  = ($urandom_range(1)) ? 100 * $urandom_range(163, 20) : $urandom_range(1972, 1948);
      mo = 2;
      dy = $urandom_range(30, 28);
      sc = $urandom_range(59, 58);
      ms = $urandom_range(1023);
    end else if (pick >= 80) begin
      y  = $urandom_range(16383);
      mo = $urandom_range(127);
      dy = $urandom_range(127);
      hr = $urandom_range(127);
      mn = $urandom_range(127);
      sc = $urandom_range(127);
      ms = $urandom_range(1023);
    end else if (pick >= 70) begin
      // Break a single field
      case ($urandom_range(6))
        0: y  = $urandom_range(1949);
        1: mo = $urandom_range(1) ? 0 : $urandom_range(127, 13);
        2: dy = $urandom_range(1) ? 0 : $urandom_range(127, 32);
        3: hr = $urandom_range(127, 24);
        4: mn = $urandom_range(127, 60);
        5: sc = $urandom_range(127, 60);
        default: begin
          sc = 59;
          ms = $urandom_range(1023, 1000);
        end
      endcase
    end else if (pick >= 60) begin
      y = $urandom_range(16383, 1950);
    end
    send_beat(y, mo, dy, hr, mn, sc, ms);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Epoch, earliest date, last ms before the epoch, end of year 9999
    send_beat(1970, 1, 1, 0, 0, 0, 0);
    send_beat(1950, 1, 1, 0, 0, 0, 0);
    send_beat(1969, 12, 31, 23, 59, 59, 999);
    send_beat(9999, 12, 31, 23, 59, 59, 999);
    // Leap years: divisible by 400, by 4, by 100 only, and a common year
    send_beat(2000, 2, 29, 12, 30, 30, 500);
    send_beat(2024, 2, 29, 0, 0, 0, 1);
    send_beat(2100, 2, 29, 0, 0, 0, 0);
    send_beat(2023, 2, 29, 0, 0, 0, 0);
    send_beat(2023, 4, 31, 0, 0, 0, 0);
    send_beat(2023, 1, 127, 0, 0, 0, 0);
    // Zero fields and years before 1950
    send_beat(0, 5, 5, 0, 0, 0, 0);
    send_beat(2000, 0, 5, 0, 0, 0, 0);
    send_beat(2000, 5, 0, 0, 0, 0, 0);
    send_beat(1949, 12, 31, 23, 59, 59, 999);
    send_beat(1900, 0, 1, 0, 0, 0, 0);
    // Time of day out of range, millisecond overflow into the second
    send_beat(2000, 1, 1, 24, 0, 0, 0);
    send_beat(2000, 1, 1, 23, 60, 0, 0);
    send_beat(2000, 1, 1, 23, 59, 60, 0);
    send_beat(2000, 1, 1, 23, 59, 59, 1000);
    send_beat(2000, 1, 1, 23, 59, 58, 1023);
    // Bad month, check order, all ones, saturation beyond 2^48 ms
    send_beat(2000, 13, 1, 0, 0, 0, 0);
    send_beat(2000, 127, 40, 99, 0, 0, 0);
    send_beat(16383, 127, 127, 127, 127, 127, 1023);
    send_beat(16383, 12, 31, 23, 59, 59, 999);
    send_beat(10889, 8, 1, 0, 0, 0, 0);
    drain();

    for (int n = 0; n < 1400; n++) begin
      steady <= (n >= 500 && n < 800);
      if (n == 1000)
        drain();
      send_random();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
